/* rtl/dpqs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dpqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W    = 16;
  localparam int SIZE_W  = 11;
  localparam int PRIO_W  = 3;
  localparam int RETRY_W = 3;
  localparam int TIME_W  = 24;
  localparam int CNT_W   = 32;
  localparam int STAT_W  = 3;
  localparam int ADM_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [ADM_W-1:0]   ADMIT_LIMIT_RST = 5'd10;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ADMIT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 1'b1;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_SERVE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED    = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_REQUEUED  = 3'd3,
    ST_LOST      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_REQ_DROP  = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_REQUEUE
  } ctrl_state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic [PRIO_W-1:0]  prio;
    logic [RETRY_W-1:0] retries;
    logic [TIME_W-1:0]  stamp;
  } pkt_t;

  // one command per cycle to a queue; push and pop never together
  typedef struct packed {
    logic push;
    logic pop;
    pkt_t pkt;
  } qcmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

/* rtl/dpqs_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dpqs_cell (
  input  logic            clk,
  input  dpqs_pkg::qcmd_t cmd,
  input  logic            occ,
  input  logic            left_stays,
  input  dpqs_pkg::pkt_t  left_pkt,
  input  dpqs_pkg::pkt_t  right_pkt,
  output dpqs_pkg::pkt_t  entry,
  output logic            ge
);
  import dpqs_pkg::*;

  pkt_t entry_r;
  pkt_t entry_nxt;

  // this entry stays put on insert: it is occupied and ranks at or above the newcomer
  assign ge = occ && (entry_r.prio >= cmd.pkt.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.pop) begin
      entry_nxt = right_pkt;
    end else if (cmd.push && !ge) begin
      entry_nxt = left_stays ? cmd.pkt : left_pkt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

/* rtl/dpqs_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module dpqs_queue #(
  parameter int DEPTH = dpqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dpqs_pkg::qcmd_t              cmd,
  output dpqs_pkg::pkt_t               head,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output dpqs_pkg::qstat_t             stat
);
  import dpqs_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;

  pkt_t       entries [DEPTH];
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] occ;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    pkt_t left_pkt;
    pkt_t right_pkt;
    logic left_stays;

    assign occ[k] = fill_r > FW'(k);

    if (k == 0) begin : g_first
      assign left_pkt   = cmd.pkt;
      assign left_stays = 1'b1;
    end else begin : g_mid
      assign left_pkt   = entries[k-1];
      assign left_stays = ge[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_pkt = entries[k];
    end else begin : g_inner
      assign right_pkt = entries[k+1];
    end

    dpqs_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[k]),
      .left_stays (left_stays),
      .left_pkt   (left_pkt),
      .right_pkt  (right_pkt),
      .entry      (entries[k]),
      .ge         (ge[k])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign head       = entries[0];
  assign fill       = fill_r;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(DEPTH));

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("queue fill beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (!stat.empty && !cmd.push))
    else $error("pop from empty queue or pop with push");
`endif

endmodule

`default_nettype wire

/* rtl/dual_priority_queue_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-queue strict priority packet scheduler with retransmission.
//
// Input channel: a transaction is taken at a rising edge with start high
// and busy low. in_kind selects arrive (store a new packet in the queue of
// in_to_uplink) or serve (take the best head, uplink winning priority ties).
// Result channel: exactly one result per transaction, shown on the out_
// ports in the cycle after acceptance, with out_valid high. The
// receiver cannot stall; results must be taken in that cycle.
// Config: cfg_we/cfg_index/cfg_wdata write admit_limit (0) and
// max_retries (1); write only while idle.
// Throughput: one transaction per cycle while busy is low. A serve
// that requeues a lost packet stalls the channel: the head pops in the
// accept cycle and the packet is inserted again in the next cycle, with
// busy high. That cost comes from each queue row taking one shift (pop or
// sorted insert) a cycle.
// Each queue is a row of cells; an insert is placed behind every entry of
// equal or higher priority, so equal priorities leave oldest first.
// Reset (rst_n, synchronous): queues empty, counters zero, limits at
// their defaults; no sweep is needed, entry contents are left as they are.
module dual_priority_queue_scheduler #(
  parameter int QUEUE_DEPTH = dpqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [dpqs_pkg::ID_W-1:0]         in_packet_id,
  input  logic [dpqs_pkg::SIZE_W-1:0]       in_packet_size,
  input  logic [dpqs_pkg::PRIO_W-1:0]       in_packet_priority,
  input  logic                              in_to_uplink,
  input  logic                              in_loss_flag,
  input  logic [dpqs_pkg::TIME_W-1:0]       in_now_time,
  // result channel
  output logic                              out_valid,
  output logic [dpqs_pkg::STAT_W-1:0]       out_status,
  output logic [dpqs_pkg::ID_W-1:0]         out_id,
  output logic [dpqs_pkg::SIZE_W-1:0]       out_size,
  output logic [dpqs_pkg::PRIO_W-1:0]       out_priority,
  output logic                              out_uplink,
  output logic [dpqs_pkg::RETRY_W-1:0]      out_retries,
  output logic [dpqs_pkg::TIME_W-1:0]       out_latency,
  output logic [dpqs_pkg::CNT_W-1:0]        out_delivered_total,
  output logic [dpqs_pkg::CNT_W-1:0]        out_lost_total,
  output logic [dpqs_pkg::CNT_W-1:0]        out_retransmit_total,
  // configuration
  input  logic                              cfg_we,
  input  logic [dpqs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpqs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dpqs_pkg::*;

  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (FW > ADM_W) ? FW : ADM_W;

  // config registers
  logic [ADM_W-1:0]   admit_limit_r;
  logic [RETRY_W-1:0] max_retries_r;

  // control
  ctrl_state_t state_r, state_nxt;
  pkt_t        pend_r, pend_nxt;       // packet waiting for its requeue insert
  logic        pend_up_r, pend_up_nxt;

  // counters
  logic [CNT_W-1:0] deliv_cnt_r, deliv_cnt_nxt;
  logic [CNT_W-1:0] lost_cnt_r, lost_cnt_nxt;
  logic [CNT_W-1:0] retx_cnt_r, retx_cnt_nxt;

  // result registers
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;
  logic               uplink_r, uplink_nxt;
  logic [RETRY_W-1:0] retries_r, retries_nxt;
  logic [TIME_W-1:0]  latency_r, latency_nxt;

  // queue interface
  qcmd_t         up_cmd, dn_cmd;
  pkt_t          up_head, dn_head;
  logic [FW-1:0] up_fill, dn_fill;
  qstat_t        up_stat, dn_stat;

  dpqs_queue #(.DEPTH(QUEUE_DEPTH)) u_up_q (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (up_cmd),
    .head  (up_head),
    .fill  (up_fill),
    .stat  (up_stat)
  );

  dpqs_queue #(.DEPTH(QUEUE_DEPTH)) u_dn_q (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (dn_cmd),
    .head  (dn_head),
    .fill  (dn_fill),
    .stat  (dn_stat)
  );

  // decode of the incoming transaction
  pkt_t          new_pkt;
  pkt_t          head_pkt;
  pkt_t          retry_pkt;
  logic          admit;
  logic          serve_up;
  logic [FW-1:0] sel_fill;
  qstat_t        sel_stat;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    new_pkt.id      = in_packet_id;
    new_pkt.size    = in_packet_size;
    new_pkt.prio    = in_packet_priority;
    new_pkt.retries = '0;
    new_pkt.stamp   = in_now_time;
  end

  assign sel_fill = in_to_uplink ? up_fill : dn_fill;
  assign sel_stat = in_to_uplink ? up_stat : dn_stat;
  // a physically full queue drops even when the limit is set higher
  assign admit    = (CW'(sel_fill) < CW'(admit_limit_r)) && !sel_stat.full;

  assign serve_up = !up_stat.empty &&
                    (dn_stat.empty || (up_head.prio >= dn_head.prio));
  assign head_pkt = serve_up ? up_head : dn_head;

  always_comb begin
    retry_pkt         = head_pkt;
    retry_pkt.retries = head_pkt.retries + RETRY_W'(1);
    retry_pkt.stamp   = in_now_time;
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    pend_up_nxt   = pend_up_r;
    deliv_cnt_nxt = deliv_cnt_r;
    lost_cnt_nxt  = lost_cnt_r;
    retx_cnt_nxt  = retx_cnt_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    id_nxt        = id_r;
    size_nxt      = size_r;
    prio_nxt      = prio_r;
    uplink_nxt    = uplink_r;
    retries_nxt   = retries_r;
    latency_nxt   = latency_r;
    up_cmd        = '{push: 1'b0, pop: 1'b0, pkt: new_pkt};
    dn_cmd        = '{push: 1'b0, pop: 1'b0, pkt: new_pkt};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          latency_nxt   = '0;
          if (in_kind == KIND_ARRIVE) begin
            id_nxt      = in_packet_id;
            size_nxt    = in_packet_size;
            prio_nxt    = in_packet_priority;
            uplink_nxt  = in_to_uplink;
            retries_nxt = '0;
            if (admit) begin
              status_nxt  = ST_QUEUED;
              up_cmd.push = in_to_uplink;
              dn_cmd.push = !in_to_uplink;
            end else begin
              status_nxt   = ST_OVERFLOW;
              lost_cnt_nxt = (lost_cnt_r == '1) ? lost_cnt_r : lost_cnt_r + CNT_W'(1);
            end
          end else if (up_stat.empty && dn_stat.empty) begin
            status_nxt  = ST_EMPTY;
            id_nxt      = '0;
            size_nxt    = '0;
            prio_nxt    = '0;
            uplink_nxt  = 1'b0;
            retries_nxt = '0;
          end else begin
            id_nxt     = head_pkt.id;
            size_nxt   = head_pkt.size;
            prio_nxt   = head_pkt.prio;
            uplink_nxt = serve_up;
            up_cmd.pop = serve_up;
            dn_cmd.pop = !serve_up;
            if (in_loss_flag) begin
              if (head_pkt.retries < max_retries_r) begin
                // after the pop the queue always has room for the retry
                status_nxt   = ST_REQUEUED;
                retries_nxt  = retry_pkt.retries;
                retx_cnt_nxt = (retx_cnt_r == '1) ? retx_cnt_r : retx_cnt_r + CNT_W'(1);
                pend_nxt     = retry_pkt;
                pend_up_nxt  = serve_up;
                state_nxt    = S_REQUEUE;
              end else begin
                status_nxt   = ST_LOST;
                retries_nxt  = head_pkt.retries;
                lost_cnt_nxt = (lost_cnt_r == '1) ? lost_cnt_r : lost_cnt_r + CNT_W'(1);
              end
            end else begin
              status_nxt    = ST_DELIVERED;
              retries_nxt   = head_pkt.retries;
              latency_nxt   = in_now_time - head_pkt.stamp;
              deliv_cnt_nxt = (deliv_cnt_r == '1) ? deliv_cnt_r : deliv_cnt_r + CNT_W'(1);
            end
          end
        end
      end
      S_REQUEUE: begin
        up_cmd.pkt  = pend_r;
        dn_cmd.pkt  = pend_r;
        up_cmd.push = pend_up_r;
        dn_cmd.push = !pend_up_r;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      deliv_cnt_r   <= '0;
      lost_cnt_r    <= '0;
      retx_cnt_r    <= '0;
      admit_limit_r <= ADMIT_LIMIT_RST;
      max_retries_r <= MAX_RETRIES_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      deliv_cnt_r <= deliv_cnt_nxt;
      lost_cnt_r  <= lost_cnt_nxt;
      retx_cnt_r  <= retx_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ADMIT_LIMIT: admit_limit_r <= cfg_wdata;
          REG_MAX_RETRIES: max_retries_r <= cfg_wdata[RETRY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pend_r    <= pend_nxt;
    pend_up_r <= pend_up_nxt;
    status_r  <= status_nxt;
    id_r      <= id_nxt;
    size_r    <= size_nxt;
    prio_r    <= prio_nxt;
    uplink_r  <= uplink_nxt;
    retries_r <= retries_nxt;
    latency_r <= latency_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_id               = id_r;
  assign out_size             = size_r;
  assign out_priority         = prio_r;
  assign out_uplink           = uplink_r;
  assign out_retries          = retries_r;
  assign out_latency          = latency_r;
  // counters only move on acceptance, so they hold through the result cycle
  assign out_delivered_total  = deliv_cnt_r;
  assign out_lost_total       = lost_cnt_r;
  assign out_retransmit_total = retx_cnt_r;

`ifndef SYNTHESIS
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("transaction without result");

  a_requeue_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REQUEUE) |=> (state_r == S_IDLE && !out_valid))
    else $error("requeue insert did not finish in one cycle");

  a_requeue_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REQUEUE) |-> (out_valid && out_status == ST_REQUEUED))
    else $error("requeue cycle without requeued result");
`endif

endmodule

`default_nettype wire

/* tb/sv/dual_priority_queue_scheduler_tb.sv */
`timescale 1ns / 1ps

module dual_priority_queue_scheduler_tb;
  import dpqs_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;

  // One result transaction as seen on the out_ ports.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic [PRIO_W-1:0]  prio;
    logic               up;
    logic [RETRY_W-1:0] retries;
    logic [TIME_W-1:0]  latency;
    logic [CNT_W-1:0]   delivered;
    logic [CNT_W-1:0]   lost;
    logic [CNT_W-1:0]   retx;
  } outcome_t;

  // Scoreboard: mirrors both priority queues and the counters, predicts the
  // outcome of every accepted command and checks results in order.
  class sched_scoreboard;
    pkt_t             up_q[$];
    pkt_t             dn_q[$];
    logic [ADM_W-1:0]   admit_limit;
    logic [RETRY_W-1:0] max_retries;
    logic [CNT_W-1:0]   delivered_cnt;
    logic [CNT_W-1:0]   lost_cnt;
    logic [CNT_W-1:0]   retx_cnt;
    outcome_t         pending_outcomes[$];
    int               bad;

    function new();
      admit_limit   = ADMIT_LIMIT_RST;
      max_retries   = MAX_RETRIES_RST;
      delivered_cnt = '0;
      lost_cnt      = '0;
      retx_cnt      = '0;
      bad           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ADMIT_LIMIT) admit_limit = val[ADM_W-1:0];
      else if (idx == REG_MAX_RETRIES) max_retries = val[RETRY_W-1:0];
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // position behind every entry of equal or higher priority
    function int slot_of(pkt_t q[$], logic [PRIO_W-1:0] prio);
      int pos;
      pos = 0;
      while (pos < q.size() && q[pos].prio >= prio) pos++;
      return pos;
    endfunction

    function void enqueue(bit up, pkt_t p);
      if (up) up_q.insert(slot_of(up_q, p.prio), p);
      else dn_q.insert(slot_of(dn_q, p.prio), p);
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void note_command(logic kind, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size,
                               logic [PRIO_W-1:0] prio, logic to_up, logic loss,
                               logic [TIME_W-1:0] now);
      outcome_t o;
      pkt_t     p;
      int       fill;
      bit       up;
      o = '0;
      if (kind == KIND_ARRIVE) begin
        up   = to_up;
        fill = up ? up_q.size() : dn_q.size();
        o.id = id;
        o.size = size;
        o.prio = prio;
        o.up = up;
        if (fill < admit_limit && fill < QDEPTH) begin
          p.id = id;
          p.size = size;
          p.prio = prio;
          p.retries = '0;
          p.stamp = now;
          enqueue(up, p);
          o.status = ST_QUEUED;
        end else begin
          lost_cnt = sat_inc(lost_cnt);
          o.status = ST_OVERFLOW;
        end
      end else if (up_q.size() == 0 && dn_q.size() == 0) begin
        o.status = ST_EMPTY;
      end else begin
        // uplink wins priority ties
        up = up_q.size() != 0 && (dn_q.size() == 0 || up_q[0].prio >= dn_q[0].prio);
        if (up) p = up_q.pop_front();
        else p = dn_q.pop_front();
        o.id = p.id;
        o.size = p.size;
        o.prio = p.prio;
        o.up = up;
        if (loss) begin
          if (p.retries < max_retries) begin
            p.retries = p.retries + 1'b1;
            p.stamp = now;
            fill = up ? up_q.size() : dn_q.size();
            if (fill < QDEPTH) begin
              enqueue(up, p);
              retx_cnt = sat_inc(retx_cnt);
              o.status = ST_REQUEUED;
            end else begin
              lost_cnt = sat_inc(lost_cnt);
              o.status = ST_REQ_DROP;
            end
          end else begin
            lost_cnt = sat_inc(lost_cnt);
            o.status = ST_LOST;
          end
        end else begin
          o.latency = now - p.stamp;
          delivered_cnt = sat_inc(delivered_cnt);
          o.status = ST_DELIVERED;
        end
        o.retries = p.retries;
      end
      o.delivered = delivered_cnt;
      o.lost = lost_cnt;
      o.retx = retx_cnt;
      pending_outcomes.push_back(o);
    endfunction

    function void check_outcome(outcome_t act);
      outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected result st=%0d id=%h", $realtime, act.status, act.id);
        return;
      end
      exp = pending_outcomes.pop_front();
      if (act !== exp) begin
        bad++;
        if (bad <= 10) begin
          $display("%0t: mismatch exp st=%0d id=%h sz=%h pr=%0d up=%0b rt=%0d lat=%h d=%0d l=%0d r=%0d",
                   $realtime, exp.status, exp.id, exp.size, exp.prio, exp.up, exp.retries,
                   exp.latency, exp.delivered, exp.lost, exp.retx);
          $display("          act st=%0d id=%h sz=%h pr=%0d up=%0b rt=%0d lat=%h d=%0d l=%0d r=%0d",
                   act.status, act.id, act.size, act.prio, act.up, act.retries,
                   act.latency, act.delivered, act.lost, act.retx);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_kind = KIND_ARRIVE;
  logic [ID_W-1:0]       in_packet_id = '0;
  logic [SIZE_W-1:0]     in_packet_size = '0;
  logic [PRIO_W-1:0]     in_packet_priority = '0;
  logic                  in_to_uplink = 1'b0;
  logic                  in_loss_flag = 1'b0;
  logic [TIME_W-1:0]     in_now_time = '0;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [ID_W-1:0]       out_id;
  logic [SIZE_W-1:0]     out_size;
  logic [PRIO_W-1:0]     out_priority;
  logic                  out_uplink;
  logic [RETRY_W-1:0]    out_retries;
  logic [TIME_W-1:0]     out_latency;
  logic [CNT_W-1:0]      out_delivered_total;
  logic [CNT_W-1:0]      out_lost_total;
  logic [CNT_W-1:0]      out_retransmit_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ADMIT_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sched_scoreboard sb = new();

  // running clock in ms for the now_time field; wraps with the field width
  logic [TIME_W-1:0] now_ms;

  dual_priority_queue_scheduler u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_packet_id         (in_packet_id),
    .in_packet_size       (in_packet_size),
    .in_packet_priority   (in_packet_priority),
    .in_to_uplink         (in_to_uplink),
    .in_loss_flag         (in_loss_flag),
    .in_now_time          (in_now_time),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_id               (out_id),
    .out_size             (out_size),
    .out_priority         (out_priority),
    .out_uplink           (out_uplink),
    .out_retries          (out_retries),
    .out_latency          (out_latency),
    .out_delivered_total  (out_delivered_total),
    .out_lost_total       (out_lost_total),
    .out_retransmit_total (out_retransmit_total),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: everything is sampled at the rising edge, before any register
  // of the block updates, so the values seen are those of the ending cycle.
  // A result belongs to an older transaction than one accepted at the same
  // edge, so check-then-note keeps the expected order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_outcome('{out_status, out_id, out_size, out_priority, out_uplink,
                           out_retries, out_latency, out_delivered_total,
                           out_lost_total, out_retransmit_total});
      if (start && !busy)
        sb.note_command(in_kind, in_packet_id, in_packet_size, in_packet_priority,
                        in_to_uplink, in_loss_flag, in_now_time);
    end
  end

  // Drive one command and hold it until the block takes it. start is left
  // high for back-to-back transactions; each idle cycle lowers it with
  // probability gap_pct.
  task automatic send_cmd(logic kind, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size,
                          logic [PRIO_W-1:0] prio, logic to_up, logic loss,
                          logic [TIME_W-1:0] now, int gap_pct);
    start              <= 1'b1;
    in_kind            <= kind;
    in_packet_id       <= id;
    in_packet_size     <= size;
    in_packet_priority <= prio;
    in_to_uplink       <= to_up;
    in_loss_flag       <= loss;
    in_now_time        <= now;
    do @(posedge clk); while (busy);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic arrive(logic to_up, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id,
                        logic [SIZE_W-1:0] size, logic [TIME_W-1:0] now);
    send_cmd(KIND_ARRIVE, id, size, prio, to_up, 1'b0, now, 0);
  endtask

  task automatic serve(logic loss, logic [TIME_W-1:0] now);
    send_cmd(KIND_SERVE, '0, '0, '0, 1'b0, loss, now, 0);
  endtask

  // Stop sending and wait for every outstanding result, then stay idle
  // so a pending requeue insert has settled before anything else happens.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    // admit limits cover zero (drop all), one, the depth and above it
    logic [CFG_DATA_W-1:0] admit_tab [9];
    logic [CFG_DATA_W-1:0] retry_tab [9];
    int gap_pct;
    int arrive_pct;
    admit_tab = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd12, 5'd16, 5'd3, 5'd5};
    retry_tab = '{5'd0, 5'd7, 5'd2, 5'd3, 5'd7, 5'd1, 5'd5, 5'd0, 5'd4};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, default limits (admit 10, retries 3) ---
    serve(1'b0, 24'd5);                                  // both queues empty
    arrive(1'b1, 3'd7, 16'h0000, 11'h000, 24'hFFFFF0);
    arrive(1'b0, 3'd7, 16'hFFFF, 11'h7FF, 24'hFFFFFF);
    arrive(1'b1, 3'd0, 16'h1234, 11'd100, 24'd1);
    serve(1'b0, 24'h000010);  // prio tie -> uplink; latency wraps
    serve(1'b1, 24'd20);      // downlink head fails: requeue, retry 1
    serve(1'b1, 24'd21);
    serve(1'b1, 24'd22);      // retry count reaches the limit
    serve(1'b1, 24'd23);      // out of retries: lost
    serve(1'b0, 24'd30);      // low-prio uplink delivered
    serve(1'b1, 24'd31);      // empty again, loss flag set
    // equal priorities fill downlink to the admit limit, then overflow
    for (int i = 0; i < 11; i++)
      arrive(1'b0, 3'd3, 16'h0100 + i[15:0], i[10:0], 24'd40 + i[23:0]);
    repeat (3) serve(1'b0, 24'd100);  // oldest leave first

    // --- random phases ---
    now_ms = TIME_W'($urandom);
    for (int ph = 0; ph < 9; ph++) begin
      // config only while idle; this also pauses the sender until all
      // expected results are back
      drain();
      set_reg(REG_ADMIT_LIMIT, admit_tab[ph]);
      set_reg(REG_MAX_RETRIES, retry_tab[ph]);
      // sender idles 18%, then 79%, then never
      gap_pct = (ph < 3) ? 18 : (ph < 6) ? 79 : 0;
      arrive_pct = 50;
      for (int n = 0; n < 122; n++) begin
        // swing the arrive/serve mix so queues fill up and run dry
        if (n % 30 == 0) arrive_pct = $urandom_range(25, 75);
        if ($urandom_range(99) < 5) now_ms = TIME_W'($urandom);
        else now_ms = TIME_W'(now_ms + $urandom_range(0, 5000));
        send_cmd(($urandom_range(99) < arrive_pct) ? KIND_ARRIVE : KIND_SERVE,
                 ID_W'($urandom), SIZE_W'($urandom), PRIO_W'($urandom),
                 1'($urandom_range(1)),
                 ($urandom_range(99) < 35), now_ms, gap_pct);
      end
    end

    drain();
    if (sb.bad == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
